[rtl/box_filter_icon_downscale_assert.svh]
// Assertion macros shared by the checker of the icon downscaler.
`ifndef BOX_FILTER_ICON_DOWNSCALE_ASSERT_SVH
`define BOX_FILTER_ICON_DOWNSCALE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BFID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bfid assertion failed");

// Next-cycle implication, checked outside reset.
`define BFID_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bfid assertion failed");

`endif

[rtl/bfid_pkg.sv]
// Types and fixed widths of the icon downscaler.
package bfid_pkg;

    // Icon size limit and largest source side; the widths below are sized for these
    localparam int MAX_ICON_DIM   = 64;
    localparam int MAX_SOURCE_DIM = 4096;

    localparam int CH_W  = 8;
    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    localparam int SUM_W = 21;
    localparam int CNT_W = 13;
    // Divider widths: dimension times icon limit, or a channel sum, over a dimension or count
    localparam int DVD_W = 22;
    localparam int DVS_W = 13;

    // Configuration register indexes
    localparam logic REG_SOURCE_WIDTH  = 1'b0;
    localparam logic REG_SOURCE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_alpha;
        logic [POS_W-1:0] out_column;
        logic [POS_W-1:0] out_row;
        logic [DIM_W-1:0] result_width;
        logic [DIM_W-1:0] result_height;
        logic             last_pixel;
    } t_pix_out;

    // One column bin accumulator entry
    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] alpha;
        logic [CNT_W-1:0] cnt;
    } t_acc;

    // Divider request and result
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/bfid_div.sv]
// Restoring divider, one quotient bit per cycle.
module bfid_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfid_pkg::t_div_req i_req,
    output bfid_pkg::t_div_rsp o_rsp
);
    import bfid_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   shifted;
    logic             qbit;

    // Trial subtraction of the divisor from the shifted partial remainder
    assign shifted = {r_rem, r_dvd[DVD_W-1]};
    assign qbit    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_dvd  <= i_req.dvd;
                r_dvs  <= i_req.dvs;
                r_rem  <= '0;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_rem  <= qbit ? DVS_W'(shifted - {1'b0, r_dvs}) : DVS_W'(shifted);
                r_dvd  <= {r_dvd[DVD_W-2:0], qbit};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dvd;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/bfid_mem.sv]
// Column bin accumulator memory with per-entry valid bits.
module bfid_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  logic           i_rd_en,
    input  logic [IW-1:0]  i_rd_addr,
    output bfid_pkg::t_acc o_rd_data,
    input  logic           i_wr_en,
    input  logic [IW-1:0]  i_wr_addr,
    input  bfid_pkg::t_acc i_wr_data
);
    import bfid_pkg::*;

    t_acc             mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_acc             r_rd_data;
    logic             r_rd_vld;

    // Storage: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Valid bits: an entry never written since restart reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/box_filter_icon_downscale.sv]
// Box filter icon downscaler: an image larger than MAX_ICON_DIM on either side is reduced by
// averaging bins of source pixels; a small image passes through. A passed-through pixel is
// registered straight into the result register. A downscaled pixel is read from memory, then
// updated and written back; a pixel that closes a bin adds four divisions on the shared
// serial divider, then a load of the result register. After reset or a configuration write
// the block works out the result size and bin steps on the same divider before it accepts
// pixels; a small image needs no such setup.
// Sums and counts live in a MAX_ICON_DIM entry memory, one per column bin.
module box_filter_icon_downscale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bfid_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bfid_pkg::t_pix_in             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bfid_pkg::t_pix_out            o_out_data
);
    import bfid_pkg::*;

    localparam int IW = (MAX_ICON_DIM > 1) ? $clog2(MAX_ICON_DIM) : 1;

    typedef enum logic [2:0] {
        S_SETUP, S_SWAIT, S_IN, S_ACC, S_DIV, S_DWAIT, S_EMIT
    } t_state;

    t_state           r_state;
    logic [1:0]       r_step;
    logic [1:0]       r_ch;
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [DIM_W-1:0] r_ow, r_oh, r_qw, r_rw, r_qh, r_rh;
    logic [DIM_W-1:0] r_scol, r_srow, r_cend, r_crem, r_rend, r_rrem;
    logic [IW-1:0]    r_bcol, r_brow;
    t_pix_in          r_px;
    t_acc             r_acc;
    logic [CH_W-1:0]  r_avg [4];
    logic [POS_W-1:0] r_ocol, r_orow;
    logic             r_olast;
    t_pix_out         r_out;
    logic             r_ovld;

    logic [DIM_W-1:0] n_scol, n_srow, n_cend, n_crem, n_rend, n_rrem;
    logic [IW-1:0]    n_bcol, n_brow;

    logic [DIM_W-1:0] wc, hc, largest;
    logic             pt, out_free, out_load, in_acc, emit;
    logic [DIM_W:0]   ctmp, rtmp;
    t_acc             rd_acc, upd_acc;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic [SUM_W-1:0] ch_sum;

    // Clamped source size and pass-through test
    always_comb begin
        wc = r_cfg_w;
        hc = r_cfg_h;
        if (r_cfg_w == '0) wc = DIM_W'(1);
        else if (int'(r_cfg_w) > MAX_SOURCE_DIM) wc = DIM_W'(MAX_SOURCE_DIM);
        if (r_cfg_h == '0) hc = DIM_W'(1);
        else if (int'(r_cfg_h) > MAX_SOURCE_DIM) hc = DIM_W'(MAX_SOURCE_DIM);
        largest = (wc > hc) ? wc : hc;
    end
    assign pt = (int'(wc) <= MAX_ICON_DIM) && (int'(hc) <= MAX_ICON_DIM);

    // Handshakes
    assign out_free   = !r_ovld || !i_out_stall;
    assign o_in_stall = !((r_state == S_IN) && (!pt || out_free));
    assign in_acc     = i_in_valid && !o_in_stall;
    // result register loads a passed-through pixel or a finished bin
    assign out_load   = (in_acc && pt) || ((r_state == S_EMIT) && out_free);

    // Position and bin stepping after one source pixel
    always_comb begin
        n_scol = r_scol;
        n_srow = r_srow;
        n_bcol = r_bcol;
        n_brow = r_brow;
        n_cend = r_cend;
        n_crem = r_crem;
        n_rend = r_rend;
        n_rrem = r_rrem;
        ctmp   = {1'b0, r_crem} + {1'b0, r_rw};
        rtmp   = {1'b0, r_rrem} + {1'b0, r_rh};
        if (!pt && ({1'b0, r_scol} + 1'b1 >= {1'b0, r_cend})
                && ((DIM_W'(r_bcol) + DIM_W'(1)) < r_ow)) begin
            n_bcol = r_bcol + IW'(1);
            if (ctmp >= {1'b0, r_ow}) begin
                n_crem = DIM_W'(ctmp - {1'b0, r_ow});
                n_cend = r_cend + r_qw + DIM_W'(1);
            end else begin
                n_crem = DIM_W'(ctmp);
                n_cend = r_cend + r_qw;
            end
        end
        if ({1'b0, r_scol} + 1'b1 >= {1'b0, wc}) begin
            n_scol = '0;
            n_bcol = '0;
            n_cend = r_qw;
            n_crem = r_rw;
            if ({1'b0, r_srow} + 1'b1 >= {1'b0, hc}) begin
                n_srow = '0;
                n_brow = '0;
                n_rend = r_qh;
                n_rrem = r_rh;
            end else begin
                n_srow = r_srow + DIM_W'(1);
                if (({1'b0, r_srow} + 1'b1 >= {1'b0, r_rend})
                        && ((DIM_W'(r_brow) + DIM_W'(1)) < r_oh)) begin
                    n_brow = r_brow + IW'(1);
                    if (rtmp >= {1'b0, r_oh}) begin
                        n_rrem = DIM_W'(rtmp - {1'b0, r_oh});
                        n_rend = r_rend + r_qh + DIM_W'(1);
                    end else begin
                        n_rrem = DIM_W'(rtmp);
                        n_rend = r_rend + r_qh;
                    end
                end
            end
        end else begin
            n_scol = r_scol + DIM_W'(1);
        end
    end

    // Accumulate the held pixel into its bin entry
    always_comb begin
        upd_acc.red   = rd_acc.red   + SUM_W'(r_px.in_red);
        upd_acc.green = rd_acc.green + SUM_W'(r_px.in_green);
        upd_acc.blue  = rd_acc.blue  + SUM_W'(r_px.in_blue);
        upd_acc.alpha = rd_acc.alpha + SUM_W'(r_px.in_alpha);
        upd_acc.cnt   = rd_acc.cnt   + CNT_W'(1);
    end
    assign emit = (r_scol + DIM_W'(1) == r_cend) && (r_srow + DIM_W'(1) == r_rend);

    bfid_mem #(
        .DEPTH (MAX_ICON_DIM),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (i_cfg_we),
        .i_rd_en   (in_acc && !pt),
        .i_rd_addr (r_bcol),
        .o_rd_data (rd_acc),
        .i_wr_en   (r_state == S_ACC),
        .i_wr_addr (r_bcol),
        .i_wr_data (emit ? '0 : upd_acc)
    );

    // Divider operands: setup steps, then channel sums over the bin count
    always_comb begin
        case (r_ch)
            2'd0:    ch_sum = r_acc.red;
            2'd1:    ch_sum = r_acc.green;
            2'd2:    ch_sum = r_acc.blue;
            default: ch_sum = r_acc.alpha;
        endcase
        div_req.start = (r_state == S_SETUP && !pt) || (r_state == S_DIV);
        div_req.dvd   = DVD_W'(ch_sum);
        div_req.dvs   = r_acc.cnt;
        if (r_state == S_SETUP) begin
            case (r_step)
                2'd0: begin
                    div_req.dvd = DVD_W'(wc) * DVD_W'(MAX_ICON_DIM);
                    div_req.dvs = largest;
                end
                2'd1: begin
                    div_req.dvd = DVD_W'(hc) * DVD_W'(MAX_ICON_DIM);
                    div_req.dvs = largest;
                end
                2'd2: begin
                    div_req.dvd = DVD_W'(wc);
                    div_req.dvs = r_ow;
                end
                default: begin
                    div_req.dvd = DVD_W'(hc);
                    div_req.dvs = r_oh;
                end
            endcase
        end
    end

    // a configuration write also abandons any division in progress
    bfid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n && !i_cfg_we),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer, position state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SETUP;
            r_step  <= '0;
            r_ch    <= '0;
            r_cfg_w <= DIM_W'(64);
            r_cfg_h <= DIM_W'(64);
            r_scol  <= '0;
            r_srow  <= '0;
            r_bcol  <= '0;
            r_brow  <= '0;
            r_ovld  <= 1'b0;
        end else if (i_cfg_we) begin
            // a write restarts the image
            if (i_cfg_idx == REG_SOURCE_WIDTH) r_cfg_w <= i_cfg_data;
            if (i_cfg_idx == REG_SOURCE_HEIGHT) r_cfg_h <= i_cfg_data;
            if (out_free) r_ovld <= 1'b0;
            r_state <= S_SETUP;
            r_step  <= '0;
            r_scol  <= '0;
            r_srow  <= '0;
            r_bcol  <= '0;
            r_brow  <= '0;
        end else begin
            if (out_load) r_ovld <= 1'b1;
            else if (out_free) r_ovld <= 1'b0;
            unique case (r_state)
                S_SETUP: begin
                    if (pt) begin
                        r_ow    <= wc;
                        r_oh    <= hc;
                        r_state <= S_IN;
                    end else begin
                        r_state <= S_SWAIT;
                    end
                end
                S_SWAIT: begin
                    if (div_rsp.done) begin
                        r_step  <= r_step + 2'd1;
                        r_state <= (r_step == 2'd3) ? S_IN : S_SETUP;
                        case (r_step)
                            2'd0: r_ow <= (div_rsp.quo == '0) ? DIM_W'(1) : DIM_W'(div_rsp.quo);
                            2'd1: r_oh <= (div_rsp.quo == '0) ? DIM_W'(1) : DIM_W'(div_rsp.quo);
                            2'd2: begin
                                r_qw <= DIM_W'(div_rsp.quo);
                                r_rw <= div_rsp.rem;
                            end
                            default: begin
                                r_qh    <= DIM_W'(div_rsp.quo);
                                r_rh    <= div_rsp.rem;
                                r_cend  <= r_qw;
                                r_crem  <= r_rw;
                                r_rend  <= DIM_W'(div_rsp.quo);
                                r_rrem  <= div_rsp.rem;
                            end
                        endcase
                    end
                end
                S_IN: begin
                    if (in_acc) begin
                        if (pt) begin
                            r_out.out_red       <= i_in_data.in_red;
                            r_out.out_green     <= i_in_data.in_green;
                            r_out.out_blue      <= i_in_data.in_blue;
                            r_out.out_alpha     <= i_in_data.in_alpha;
                            r_out.out_column    <= POS_W'(r_scol);
                            r_out.out_row       <= POS_W'(r_srow);
                            r_out.result_width  <= wc;
                            r_out.result_height <= hc;
                            r_out.last_pixel    <= (r_scol + DIM_W'(1) == wc)
                                                   && (r_srow + DIM_W'(1) == hc);
                            r_scol <= n_scol;
                            r_srow <= n_srow;
                            r_bcol <= n_bcol;
                            r_brow <= n_brow;
                            r_cend <= n_cend;
                            r_crem <= n_crem;
                            r_rend <= n_rend;
                            r_rrem <= n_rrem;
                        end else begin
                            r_px    <= i_in_data;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_ocol  <= POS_W'(r_bcol);
                    r_orow  <= POS_W'(r_brow);
                    r_olast <= (DIM_W'(r_bcol) + DIM_W'(1) == r_ow)
                               && (DIM_W'(r_brow) + DIM_W'(1) == r_oh);
                    r_acc   <= upd_acc;
                    r_ch    <= '0;
                    r_state <= emit ? S_DIV : S_IN;
                    r_scol  <= n_scol;
                    r_srow  <= n_srow;
                    r_bcol  <= n_bcol;
                    r_brow  <= n_brow;
                    r_cend  <= n_cend;
                    r_crem  <= n_crem;
                    r_rend  <= n_rend;
                    r_rrem  <= n_rrem;
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_avg[r_ch] <= div_rsp.quo[CH_W-1:0];
                        r_ch        <= r_ch + 2'd1;
                        r_state     <= (r_ch == 2'd3) ? S_EMIT : S_DIV;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out.out_red       <= r_avg[0];
                        r_out.out_green     <= r_avg[1];
                        r_out.out_blue      <= r_avg[2];
                        r_out.out_alpha     <= r_avg[3];
                        r_out.out_column    <= r_ocol;
                        r_out.out_row       <= r_orow;
                        r_out.result_width  <= r_ow;
                        r_out.result_height <= r_oh;
                        r_out.last_pixel    <= r_olast;
                        r_state <= S_IN;
                    end
                end
                default: r_state <= S_SETUP;
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

[rtl/bfid_chk.sv]
// Port-level checker of the icon downscaler and its bind.
`include "box_filter_icon_downscale_assert.svh"

module bfid_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input bfid_pkg::t_pix_out   o_out_data
);
    import bfid_pkg::*;

    // a stalled result holds
    `BFID_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // a restart blocks input while sizes are worked out
    `BFID_ASSERT_NXT(a_cfg_stall, i_cfg_we, o_in_stall)
    // result position lies inside the result image
    `BFID_ASSERT_NOW(a_pos_in, o_out_valid,
        (DIM_W'(o_out_data.out_column) < o_out_data.result_width)
        && (DIM_W'(o_out_data.out_row) < o_out_data.result_height))
    // the last pixel sits in the bottom-right corner
    `BFID_ASSERT_NOW(a_last_pos, o_out_valid && o_out_data.last_pixel,
        (DIM_W'(o_out_data.out_column) + DIM_W'(1) == o_out_data.result_width)
        && (DIM_W'(o_out_data.out_row) + DIM_W'(1) == o_out_data.result_height))

endmodule

bind box_filter_icon_downscale bfid_chk u_bfid_chk (.*);
